// File: design/cubic_bezier_point_eval_macros.svh
`ifndef CUBIC_BEZIER_POINT_EVAL_MACROS_SVH
`define CUBIC_BEZIER_POINT_EVAL_MACROS_SVH

// same-cycle implication, quiet during reset
`define CBPE_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet during reset
`define CBPE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication, also checked across reset
`define CBPE_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/cbpe_pkg.sv
`default_nettype none

package cbpe_pkg;

   localparam int T_BITS         = 18;
   localparam int COORD_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int CFG_REG_COUNT  = 8;
   localparam int CFG_IDX_BITS   = $clog2(CFG_REG_COUNT);

   typedef enum logic [CFG_IDX_BITS-1:0] {
      REG_START_X,
      REG_START_Y,
      REG_CTRL1_X,
      REG_CTRL1_Y,
      REG_CTRL2_X,
      REG_CTRL2_Y,
      REG_FINISH_X,
      REG_FINISH_Y
   } cfg_reg_type;

   typedef struct packed {
      logic valid;
      logic sel_start;
      logic sel_finish;
   } stage_ctrl_type;

endpackage

`default_nettype wire

// File: design/cbpe_req_if.sv
`default_nettype none

interface cbpe_req_if import cbpe_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic signed [T_BITS-1:0] param_t;

   modport source (output valid, output param_t, input ready);
   modport sink   (input valid, input param_t, output ready);
endinterface

`default_nettype wire

// File: design/cbpe_rsp_if.sv
`default_nettype none

interface cbpe_rsp_if import cbpe_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] point_x;
   logic signed [COORD_BITS-1:0] point_y;

   modport source (output valid, output point_x, output point_y, input ready);
   modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

`default_nettype wire

// File: design/cbpe_weight.sv
`default_nettype none

module cbpe_weight import cbpe_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        enable,
   input  wire                        in_valid,
   input  wire  signed [T_BITS-1:0]   param_t,
   output stage_ctrl_type             ctrl_out,
   output logic [3*FRAC_BITS:0]       weight_out [4]
);

   localparam int FB  = FRAC_BITS;
   localparam int TPW = FB + 1;
   localparam int SQW = 2 * FB + 1;
   localparam int WW  = 3 * FB + 1;
   localparam int P2W = 2 * TPW;
   localparam int P3W = SQW + TPW;
   localparam int TCW = (T_BITS > FB + 2) ? T_BITS : FB + 2;

   localparam logic [TCW-1:0] ONE_T = TCW'(1) << FB;
   localparam logic [TPW-1:0] ONE_U = TPW'(1) << FB;

   // stage 1: range check, t and u
   logic signed [TCW-1:0] t_ext;
   logic                  t_neg, t_over;
   stage_ctrl_type        ctrl1_in, ctrl1_ff;
   logic [TPW-1:0]        t1_in, u1_in, t1_ff, u1_ff;

   assign t_ext  = TCW'(param_t);
   assign t_neg  = t_ext[TCW-1];
   assign t_over = !t_neg && ($unsigned(t_ext) > ONE_T);
   assign t1_in  = t_ext[FB:0];
   assign u1_in  = ONE_U - t1_in;

   assign ctrl1_in.valid      = in_valid;
   assign ctrl1_in.sel_start  = t_neg;
   assign ctrl1_in.sel_finish = t_over;

   // stage 2: squares and cross product
   stage_ctrl_type ctrl2_ff;
   logic [P2W-1:0] tt_prod, uu_prod, ut_prod;
   logic [SQW-1:0] tt2_ff, uu2_ff, ut2_ff;
   logic [TPW-1:0] t2_ff, u2_ff;

   assign tt_prod = P2W'(t1_ff) * P2W'(t1_ff);
   assign uu_prod = P2W'(u1_ff) * P2W'(u1_ff);
   assign ut_prod = P2W'(u1_ff) * P2W'(t1_ff);

   // stage 3: Bernstein weights, middle two scaled by three
   stage_ctrl_type ctrl3_ff;
   logic [P3W-1:0] uuu_prod, uut_prod, utt_prod, ttt_prod;
   logic [WW-1:0]  uut_w, utt_w;
   logic [WW-1:0]  weight_in [4];
   logic [WW-1:0]  weight_ff [4];

   assign uuu_prod = P3W'(uu2_ff) * P3W'(u2_ff);
   assign uut_prod = P3W'(uu2_ff) * P3W'(t2_ff);
   assign utt_prod = P3W'(ut2_ff) * P3W'(t2_ff);
   assign ttt_prod = P3W'(tt2_ff) * P3W'(t2_ff);
   assign uut_w    = uut_prod[WW-1:0];
   assign utt_w    = utt_prod[WW-1:0];

   assign weight_in[0] = uuu_prod[WW-1:0];
   assign weight_in[1] = uut_w + (uut_w << 1);
   assign weight_in[2] = utt_w + (utt_w << 1);
   assign weight_in[3] = ttt_prod[WW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl1_ff <= '0;
         ctrl2_ff <= '0;
         ctrl3_ff <= '0;
      end else if (enable) begin
         ctrl1_ff <= ctrl1_in;
         ctrl2_ff <= ctrl1_ff;
         ctrl3_ff <= ctrl2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         t1_ff  <= t1_in;
         u1_ff  <= u1_in;
         tt2_ff <= tt_prod[SQW-1:0];
         uu2_ff <= uu_prod[SQW-1:0];
         ut2_ff <= ut_prod[SQW-1:0];
         t2_ff  <= t1_ff;
         u2_ff  <= u1_ff;
         for (int k = 0; k < 4; k++) begin
            weight_ff[k] <= weight_in[k];
         end
      end
   end

   assign ctrl_out = ctrl3_ff;
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         weight_out[k] = weight_ff[k];
      end
   end

endmodule

`default_nettype wire

// File: design/cbpe_axis.sv
`default_nettype none

module cbpe_axis import cbpe_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          enable,
   input  wire  stage_ctrl_type         ctrl_in,
   input  wire  [3*FRAC_BITS:0]         weight_in [4],
   input  wire  signed [COORD_BITS-1:0] coord_in [4],
   output stage_ctrl_type               ctrl_out,
   output logic signed [COORD_BITS-1:0] point_out
);

   localparam int C   = COORD_BITS;
   localparam int SH  = 3 * FRAC_BITS;
   localparam int WW  = SH + 1;
   localparam int LOW = (WW + 1) / 2;
   localparam int HIW = WW - LOW;
   localparam int PLW = C + LOW + 1;
   localparam int PHW = C + HIW + 1;
   localparam int TW  = C + WW + 1;

   localparam logic [TW-1:0] RND = (TW'(1) << SH) - TW'(1);

   stage_ctrl_type ctrl4_ff, ctrl5_ff, ctrl6_ff, ctrl7_ff;

   // stage 4: coordinate times low and high halves of its weight
   logic signed [PLW-1:0] plo_in [4];
   logic signed [PHW-1:0] phi_in [4];
   logic signed [PLW-1:0] plo_ff [4];
   logic signed [PHW-1:0] phi_ff [4];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         plo_in[k] = PLW'($signed(coord_in[k]))
                   * PLW'($signed({1'b0, weight_in[k][LOW-1:0]}));
         phi_in[k] = PHW'($signed(coord_in[k]))
                   * PHW'($signed({1'b0, weight_in[k][WW-1:LOW]}));
      end
   end

   // stage 5: merge halves into one term
   logic signed [TW-1:0] term_in [4];
   logic signed [TW-1:0] term_ff [4];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         term_in[k] = (TW'(phi_ff[k]) <<< LOW) + TW'(plo_ff[k]);
      end
   end

   // stages 6 and 7: adder tree
   logic signed [TW-1:0] pair_ff [2];
   logic signed [TW-1:0] sum_ff;

   // final: divide by 2^SH toward zero, then pick clamped end points
   logic signed [TW-1:0] biased;
   logic signed [TW-1:0] quot;

   assign biased = sum_ff + $signed(sum_ff[TW-1] ? RND : TW'(0));
   assign quot   = biased >>> SH;

   always_comb begin
      if (ctrl7_ff.sel_start) begin
         point_out = coord_in[0];
      end else if (ctrl7_ff.sel_finish) begin
         point_out = coord_in[3];
      end else begin
         point_out = quot[C-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl4_ff <= '0;
         ctrl5_ff <= '0;
         ctrl6_ff <= '0;
         ctrl7_ff <= '0;
      end else if (enable) begin
         ctrl4_ff <= ctrl_in;
         ctrl5_ff <= ctrl4_ff;
         ctrl6_ff <= ctrl5_ff;
         ctrl7_ff <= ctrl6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < 4; k++) begin
            plo_ff[k]  <= plo_in[k];
            phi_ff[k]  <= phi_in[k];
            term_ff[k] <= term_in[k];
         end
         pair_ff[0] <= term_ff[0] + term_ff[1];
         pair_ff[1] <= term_ff[2] + term_ff[3];
         sum_ff     <= pair_ff[0] + pair_ff[1];
      end
   end

   assign ctrl_out = ctrl7_ff;

endmodule

`default_nettype wire

// File: design/cubic_bezier_point_eval.sv
// A request taken on req passes through pipeline stages 1 to 7 and then the output register before it shows on rsp.
// Throughput: one request per cycle while the skid entry is empty; seven pipeline stages feed an output register.
// A two-entry output buffer (output register plus skid) freezes the pipeline on backpressure.
// Reset clears all control points to zero and empties the pipeline and output buffer.
`default_nettype none

module cubic_bezier_point_eval import cbpe_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     csr_we,
   input  wire  [CFG_IDX_BITS-1:0] csr_index,
   input  wire  [COORD_BITS-1:0]   csr_wdata,
   cbpe_req_if.sink                req_ch,
   cbpe_rsp_if.source              rsp_ch
);

   localparam int C = COORD_BITS;

   // control point registers
   logic [C-1:0] start_x_ff, start_y_ff, ctrl1_x_ff, ctrl1_y_ff;
   logic [C-1:0] ctrl2_x_ff, ctrl2_y_ff, finish_x_ff, finish_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff  <= '0;
         start_y_ff  <= '0;
         ctrl1_x_ff  <= '0;
         ctrl1_y_ff  <= '0;
         ctrl2_x_ff  <= '0;
         ctrl2_y_ff  <= '0;
         finish_x_ff <= '0;
         finish_y_ff <= '0;
      end else if (csr_we) begin
         unique case (cfg_reg_type'(csr_index))
            REG_START_X:  start_x_ff  <= csr_wdata;
            REG_START_Y:  start_y_ff  <= csr_wdata;
            REG_CTRL1_X:  ctrl1_x_ff  <= csr_wdata;
            REG_CTRL1_Y:  ctrl1_y_ff  <= csr_wdata;
            REG_CTRL2_X:  ctrl2_x_ff  <= csr_wdata;
            REG_CTRL2_Y:  ctrl2_y_ff  <= csr_wdata;
            REG_FINISH_X: finish_x_ff <= csr_wdata;
            REG_FINISH_Y: finish_y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic signed [C-1:0] coord_x [4];
   logic signed [C-1:0] coord_y [4];

   assign coord_x[0] = start_x_ff;
   assign coord_x[1] = ctrl1_x_ff;
   assign coord_x[2] = ctrl2_x_ff;
   assign coord_x[3] = finish_x_ff;
   assign coord_y[0] = start_y_ff;
   assign coord_y[1] = ctrl1_y_ff;
   assign coord_y[2] = ctrl2_y_ff;
   assign coord_y[3] = finish_y_ff;

   // pipeline
   logic                  enable;
   stage_ctrl_type        ctrl_w, ctrl_x, ctrl_y;
   logic [3*FRAC_BITS:0]  weight [4];
   logic signed [C-1:0]   new_x, new_y;

   cbpe_weight #(
      .FRAC_BITS (FRAC_BITS)
   ) u_weight (
      .clock      (clock),
      .reset      (reset),
      .enable     (enable),
      .in_valid   (req_ch.valid),
      .param_t    (req_ch.param_t),
      .ctrl_out   (ctrl_w),
      .weight_out (weight)
   );

   cbpe_axis #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_axis_x (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .ctrl_in   (ctrl_w),
      .weight_in (weight),
      .coord_in  (coord_x),
      .ctrl_out  (ctrl_x),
      .point_out (new_x)
   );

   cbpe_axis #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_axis_y (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .ctrl_in   (ctrl_w),
      .weight_in (weight),
      .coord_in  (coord_y),
      .ctrl_out  (ctrl_y),
      .point_out (new_y)
   );

   // output register and skid entry
   logic                out_valid_in, out_valid_ff;
   logic                skid_valid_in, skid_valid_ff;
   logic signed [C-1:0] out_x_in, out_y_in, out_x_ff, out_y_ff;
   logic signed [C-1:0] skid_x_in, skid_y_in, skid_x_ff, skid_y_ff;
   logic                emerge;

   // freeze the pipeline only while the skid entry holds a result
   assign enable = !skid_valid_ff;
   assign emerge = enable && ctrl_x.valid && ctrl_y.valid;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_x_in      = out_x_ff;
      out_y_in      = out_y_ff;
      skid_valid_in = skid_valid_ff;
      skid_x_in     = skid_x_ff;
      skid_y_in     = skid_y_ff;
      if (!out_valid_ff || rsp_ch.ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_x_in      = skid_x_ff;
            out_y_in      = skid_y_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = emerge;
            out_x_in     = new_x;
            out_y_in     = new_y;
         end
      end else if (emerge) begin
         // hold the new result aside while the output stalls
         skid_valid_in = 1'b1;
         skid_x_in     = new_x;
         skid_y_in     = new_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_x_ff  <= out_x_in;
      out_y_ff  <= out_y_in;
      skid_x_ff <= skid_x_in;
      skid_y_ff <= skid_y_in;
   end

   assign req_ch.ready   = enable;
   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.point_x = out_x_ff;
   assign rsp_ch.point_y = out_y_ff;

endmodule

`default_nettype wire

// File: design/cbpe_checker.sv
`default_nettype none

`include "cubic_bezier_point_eval_macros.svh"

module cbpe_checker import cbpe_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input wire                  clock,
   input wire                  reset,
   input wire                  req_valid,
   input wire                  req_ready,
   input wire                  rsp_valid,
   input wire                  rsp_ready,
   input wire [COORD_BITS-1:0] point_x,
   input wire [COORD_BITS-1:0] point_y
);

   logic rsp_stall;

   assign rsp_stall = rsp_valid && !rsp_ready;

   `CBPE_ASSERT_NEXT(a_rsp_valid_holds, clock, reset, rsp_stall, rsp_valid, "rsp valid dropped while stalled")
   `CBPE_ASSERT_NEXT(a_rsp_point_holds, clock, reset, rsp_stall, $stable(point_x) && $stable(point_y), "rsp point changed while stalled")
   `CBPE_ASSERT_NEXT_ALWAYS(a_reset_empties, clock, reset, !rsp_valid && req_ready, "reset left a result or a stall behind")
   `CBPE_ASSERT_IMPLY(a_backpressure_cause, clock, reset, !req_ready, rsp_valid, "req stalled with no result pending")
   `CBPE_ASSERT_NEXT(a_stall_needs_full_out, clock, reset, !req_ready && req_valid, rsp_valid, "req stalled while output drained")

endmodule

bind cubic_bezier_point_eval cbpe_checker #(
   .COORD_BITS (COORD_BITS)
) u_cbpe_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .point_x   (rsp_ch.point_x),
   .point_y   (rsp_ch.point_y)
);

`default_nettype wire
